// ----- design/cdt_pkg.sv -----
`timescale 1ns / 1ps

package cdt_pkg;

  // Event codes carried by the operation field.
  typedef enum logic [1:0] {
    OpKey     = 2'd0,
    OpSecond  = 2'd1,
    OpRefresh = 2'd2,
    OpBlink   = 2'd3
  } op_e;

  // Key codes that have an effect.
  localparam logic [3:0] KeyZero  = 4'd0;
  localparam logic [3:0] KeyOne   = 4'd1;
  localparam logic [3:0] KeyThree = 4'd3;
  localparam logic [3:0] KeyA     = 4'd10;
  localparam logic [3:0] KeyB     = 4'd11;
  localparam logic [3:0] KeyC     = 4'd12;
  localparam logic [3:0] KeyD     = 4'd15;

  // Count limits.
  localparam logic [6:0] MinuteMax = 7'd99;
  localparam logic [5:0] SecondMax = 6'd59;

  // Segment pattern that leaves the display dark.
  localparam logic [7:0] SegBlank = 8'hFF;

  // One input event.
  typedef struct packed {
    op_e        operation;
    logic [3:0] key_code;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [3:0] digit_enable_n;
    logic [7:0] segments_n;
    logic       leds_lit;
    logic [6:0] minutes_now;
    logic [5:0] seconds_now;
    logic       is_running;
    logic       is_setting;
    logic       alarm_active;
  } out_item_t;

  // Active-low seven-segment pattern of one decimal digit, decimal point off.
  function automatic logic [7:0] seg_encode(input logic [3:0] digit);
    logic [7:0] seg;
    unique case (digit)
      4'd0:    seg = 8'b1100_0000;
      4'd1:    seg = 8'b1111_1001;
      4'd2:    seg = 8'b1010_0100;
      4'd3:    seg = 8'b1011_0000;
      4'd4:    seg = 8'b1001_1001;
      4'd5:    seg = 8'b1001_0010;
      4'd6:    seg = 8'b1000_0010;
      4'd7:    seg = 8'b1111_1000;
      4'd8:    seg = 8'b1000_0000;
      4'd9:    seg = 8'b1001_0000;
      default: seg = SegBlank;
    endcase
    return seg;
  endfunction

endpackage

// ----- design/countdown_timer_with_display_core.sv -----
`timescale 1ns / 1ps

// Minutes:seconds countdown timer with a four-digit multiplexed display.
// Each input transfer is one event (key press, one-second tick, refresh tick
// or blink tick); it updates the timer state in the cycle it is taken and
// yields exactly one result, a snapshot of the state after the event, which
// is registered in the result buffer. One event is taken every clock cycle
// while the buffer has room: the whole update is a single pass of logic from
// the state registers to the result register, and a two-entry result buffer
// takes one more event while the consumer holds off out_ready_i. Before the
// first refresh tick the display reads all dark with no digit selected.
module countdown_timer_with_display_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cdt_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cdt_pkg::out_item_t  out_data_o
);
  import cdt_pkg::*;

  // Timer state.
  logic [6:0] minutes_q, minutes_d;
  logic [5:0] seconds_q, seconds_d;
  logic [1:0] pos_q, pos_d;
  logic       set_q, set_d;
  logic       run_q, run_d;
  logic       alarm_q, alarm_d;
  logic       blink_q, blink_d;
  logic [7:0] seg_q, seg_d;

  // Result buffer: head register and skid register.
  out_item_t  head_q, skid_q, result;
  logic       head_valid_q, skid_valid_q;
  logic       push, pop;

  // Display digit selection.
  logic [3:0] shown_digit;
  logic [6:0] split_val;
  logic [14:0] tens_prod;
  logic [3:0] tens_raw, tens_dig, ones_dig;

  assign in_ready_o  = !skid_valid_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = head_valid_q && out_ready_i;
  assign out_valid_o = head_valid_q;
  assign out_data_o  = head_q;

  // Split the selected count into tens and ones (reciprocal multiply by 205/2048).
  always_comb begin
    split_val = pos_q[1] ? minutes_q : {1'b0, seconds_q};
    tens_prod = 15'(split_val) * 15'd205;
    tens_raw  = tens_prod[14:11];
    ones_dig  = 4'(split_val - 7'(tens_raw) * 7'd10);
    tens_dig  = (tens_raw >= 4'd10) ? 4'(tens_raw - 4'd10) : tens_raw;
    shown_digit = pos_q[0] ? tens_dig : ones_dig;
  end

  // Next timer state for the current event.
  always_comb begin
    minutes_d = minutes_q;
    seconds_d = seconds_q;
    pos_d     = pos_q;
    set_d     = set_q;
    run_d     = run_q;
    alarm_d   = alarm_q;
    blink_d   = blink_q;
    seg_d     = seg_q;

    unique case (in_data_i.operation)
      OpKey: begin
        if (alarm_q) begin
          alarm_d = 1'b0;
          blink_d = 1'b0;
        end else if (in_data_i.key_code == KeyA) begin
          set_d = 1'b1;
        end else if (in_data_i.key_code == KeyB) begin
          set_d = 1'b0;
        end else if (set_q) begin
          if (in_data_i.key_code == KeyOne) begin
            minutes_d = (minutes_q >= MinuteMax) ? 7'd0 : 7'(minutes_q + 7'd1);
          end else if (in_data_i.key_code == KeyThree) begin
            seconds_d = (seconds_q >= SecondMax) ? 6'd0 : 6'(seconds_q + 6'd1);
          end else if (in_data_i.key_code == KeyZero) begin
            minutes_d = 7'd0;
            seconds_d = 6'd0;
          end
        end else begin
          if (in_data_i.key_code == KeyD) begin
            run_d = 1'b1;
          end else if (in_data_i.key_code == KeyC) begin
            run_d = 1'b0;
          end
        end
      end
      OpSecond: begin
        if (run_q) begin
          if (seconds_q == 6'd0) begin
            if (minutes_q != 7'd0) begin
              minutes_d = 7'(minutes_q - 7'd1);
            end
            seconds_d = SecondMax;
          end else begin
            seconds_d = 6'(seconds_q - 6'd1);
          end
        end
      end
      OpRefresh: begin
        seg_d = seg_encode(shown_digit);
        pos_d = 2'(pos_q + 2'd1);
      end
      OpBlink: begin
        blink_d = alarm_q ? !blink_q : 1'b0;
      end
      default: ;
    endcase

    // Reaching zero while running stops the count and raises the alarm.
    if (run_d && minutes_d == 7'd0 && seconds_d == 6'd0) begin
      run_d   = 1'b0;
      alarm_d = 1'b1;
      blink_d = 1'b0;
    end
  end

  // Result snapshot after the update.
  always_comb begin
    result.digit_enable_n = (seg_d == SegBlank) ? 4'hF
                                                : ~(4'b0001 << 2'(pos_d + 2'd3));
    result.segments_n     = seg_d;
    result.leds_lit       = alarm_d && blink_d;
    result.minutes_now    = minutes_d;
    result.seconds_now    = seconds_d;
    result.is_running     = run_d;
    result.is_setting     = set_d;
    result.alarm_active   = alarm_d;
  end

  // Timer state registers, updated on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minutes_q <= 7'd0;
      seconds_q <= 6'd0;
      pos_q     <= 2'd0;
      set_q     <= 1'b0;
      run_q     <= 1'b0;
      alarm_q   <= 1'b0;
      blink_q   <= 1'b0;
      seg_q     <= SegBlank;
    end else if (push) begin
      minutes_q <= minutes_d;
      seconds_q <= seconds_d;
      pos_q     <= pos_d;
      set_q     <= set_d;
      run_q     <= run_d;
      alarm_q   <= alarm_d;
      blink_q   <= blink_d;
      seg_q     <= seg_d;
    end
  end

  // Result buffer valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!head_valid_q) begin
        head_valid_q <= push;
      end else if (pop) begin
        head_valid_q <= skid_valid_q || push;
        skid_valid_q <= 1'b0;
      end else if (push) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Result buffer payload.
  always_ff @(posedge clk_i) begin
    if (!head_valid_q || pop) begin
      head_q <= skid_valid_q ? skid_q : result;
    end
    if (head_valid_q && !pop && push) begin
      skid_q <= result;
    end
  end

  // The count never leaves its legal range.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seconds_q <= SecondMax) && (minutes_q <= MinuteMax))
    else $error("timer count out of range");

  // Running and alarm exclude each other.
  a_run_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(run_q && alarm_q))
    else $error("timer running while alarm is active");

  // The blink phase is lit only during an alarm.
  a_blink_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blink_q |-> alarm_q)
    else $error("blink phase lit without alarm");

  // The skid entry is only used behind a waiting head entry.
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> head_valid_q)
    else $error("skid entry valid with empty head");

endmodule
